@@ sv/chbd_pkg.sv @@
`default_nettype none

package chbd_pkg;

    // Datapath widths of the decoder.
    localparam int SIZE_WIDTH      = 32;
    localparam int TOTAL_WIDTH     = 48;
    localparam int MAX_SIZE_W      = 32;
    localparam int OUT_TOTAL_W     = 48;
    localparam int CMP_W           = (SIZE_WIDTH > MAX_SIZE_W) ? SIZE_WIDTH : MAX_SIZE_W;
    localparam int DIGIT_W         = 4;

    // Characters that the framing looks for.
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_BIT = 8'h20;

    // Reset value of the largest accepted chunk size.
    localparam logic [MAX_SIZE_W-1:0] MAX_SIZE_RESET = 32'h0100_0000;

    // Parser phase.
    typedef enum logic [2:0] {
        PH_SIZE    = 3'd0,
        PH_EXT     = 3'd1,
        PH_DATA    = 3'd2,
        PH_DATA_CR = 3'd3,
        PH_DATA_LF = 3'd4,
        PH_TRAILER = 3'd5,
        PH_DONE    = 3'd6,
        PH_ERROR   = 3'd7
    } t_phase;

    // What an output byte is.
    typedef enum logic [1:0] {
        KIND_FRAMING = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_TRAILER = 2'd2,
        KIND_IGNORED = 2'd3
    } t_kind;

    // Body status after a byte.
    typedef enum logic [1:0] {
        ST_MORE    = 2'd0,
        ST_DONE    = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    // Size line flags.
    typedef struct packed {
        logic cr;
        logic over;
        logic space;
        logic digit;
    } t_size_flags;

    // One result item handed from the parser to the output stage.
    typedef struct packed {
        t_kind                  kind;
        logic [7:0]             out_byte;
        t_status                status;
        logic [OUT_TOTAL_W-1:0] total;
    } t_result;

endpackage

`default_nettype wire

@@ sv/http_chunked_body_decoder_unit.sv @@
`default_nettype none

// Chunked HTTP body decoder. One body byte enters per transfer on the slave
// stream and exactly one result leaves on the master stream for it, in order.
// A byte is taken every clock cycle: the parser updates its state with short
// logic in the cycle of the transfer and the result lands in an output
// register backed by a one-entry skid register, so the input keeps flowing
// while the output is stalled and stops only when both are full. Set tuser
// bit 0 on the first byte of a new body to clear the parser. The maximum
// chunk size register (reset 16777216) may be written only while no byte is
// in flight.
module http_chunked_body_decoder_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Configuration: largest accepted chunk size.
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [chbd_pkg::MAX_SIZE_W-1:0] i_cfg_wr_data,
    // Input stream.
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [7:0]                      s_axis_tdata,  // [7:0] in_byte
    input  wire logic [0:0]                      s_axis_tuser,  // [0] restart
    // Output stream.
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [7:0] out_byte, [9:8] body_status, [57:10] payload_total, [63:58] zero
    output logic [63:0]                          m_axis_tdata,
    output logic [1:0]                           m_axis_tuser   // [1:0] byte_kind
);
    import chbd_pkg::*;

    logic [MAX_SIZE_W-1:0] r_max_size;
    logic                  in_xfer;
    logic                  out_xfer;
    t_result               result;
    t_result               r_main, r_skid;
    logic                  r_main_valid, r_skid_valid;

    assign s_axis_tready = !r_skid_valid;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = r_main_valid && m_axis_tready;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_size <= MAX_SIZE_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_size <= i_cfg_wr_data;
        end
    end

    chbd_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_xfer),
        .i_byte     (s_axis_tdata),
        .i_restart  (s_axis_tuser[0]),
        .i_max_size (r_max_size),
        .o_result   (result)
    );

    // Output register with skid entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_xfer) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= in_xfer;
            end
        end else if (in_xfer) begin
            if (r_main_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end
    end

    // Payload of the two entries.
    always_ff @(posedge i_clk) begin
        if (out_xfer) begin
            r_main <= r_skid_valid ? r_skid : result;
        end else if (in_xfer) begin
            if (r_main_valid) begin
                r_skid <= result;
            end else begin
                r_main <= result;
            end
        end
    end

    assign m_axis_tvalid = r_main_valid;
    assign m_axis_tuser  = r_main.kind;
    assign m_axis_tdata  = {6'b0, r_main.total, r_main.status, r_main.out_byte};

endmodule

`default_nettype wire

@@ sv/chbd_parser.sv @@
`default_nettype none

module chbd_parser (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic [7:0]                    i_byte,
    input  wire logic                          i_restart,
    input  wire logic [chbd_pkg::MAX_SIZE_W-1:0] i_max_size,
    output chbd_pkg::t_result                  o_result
);
    import chbd_pkg::*;

    // Parser state.
    t_phase                 r_phase, n_phase;
    logic [SIZE_WIDTH-1:0]  r_accum, n_accum;
    t_size_flags            r_flags, n_flags;
    logic [SIZE_WIDTH-1:0]  r_left, n_left;
    logic [TOTAL_WIDTH-1:0] r_total, n_total;
    logic                   r_tcr, n_tcr;

    // State as seen by this byte, after an optional restart.
    t_phase                 e_phase;
    logic [SIZE_WIDTH-1:0]  e_accum;
    t_size_flags            e_flags;
    logic [SIZE_WIDTH-1:0]  e_left;
    logic [TOTAL_WIDTH-1:0] e_total;
    logic                   e_tcr;

    logic                   hex_ok;
    logic [DIGIT_W-1:0]     hex_val;
    logic                   top_nibble_used;
    logic                   size_bad;
    logic [SIZE_WIDTH-1:0]  left_dec;
    t_kind                  kind;
    logic [7:0]             obyte;
    t_status                status;

    assign e_phase = i_restart ? PH_SIZE : r_phase;
    assign e_accum = i_restart ? '0 : r_accum;
    assign e_flags = i_restart ? '0 : r_flags;
    assign e_left  = i_restart ? '0 : r_left;
    assign e_total = i_restart ? '0 : r_total;
    assign e_tcr   = i_restart ? 1'b0 : r_tcr;

    // Hex digit decode of the incoming byte.
    always_comb begin
        hex_ok  = 1'b1;
        hex_val = '0;
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            hex_val = DIGIT_W'(i_byte - 8'h30);
        end else if (i_byte >= 8'h61 && i_byte <= 8'h66) begin
            hex_val = DIGIT_W'(i_byte - 8'h57);
        end else if (i_byte >= 8'h41 && i_byte <= 8'h46) begin
            hex_val = DIGIT_W'(i_byte - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
    end

    // A size line is rejected at its LF if empty, spaced, too large or over the limit.
    assign top_nibble_used = |e_accum[SIZE_WIDTH-1 -: DIGIT_W];
    assign size_bad = !e_flags.digit || e_flags.space || e_flags.over ||
                      (CMP_W'(e_accum) > CMP_W'(i_max_size));
    assign left_dec = e_left - SIZE_WIDTH'(1);

    // Next phase.
    always_comb begin
        n_phase = e_phase;
        case (e_phase)
            PH_SIZE, PH_EXT: begin
                if (e_flags.cr) begin
                    if (i_byte != CH_LF || size_bad) begin
                        n_phase = PH_ERROR;
                    end else if (e_accum == '0) begin
                        n_phase = PH_TRAILER;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end else if (i_byte == CH_CR || e_phase == PH_EXT) begin
                    n_phase = e_phase;
                end else if (i_byte == CH_SEMI) begin
                    n_phase = PH_EXT;
                end else if (i_byte != CH_SPACE && !hex_ok) begin
                    n_phase = PH_ERROR;
                end
            end
            PH_DATA: begin
                if (left_dec == '0) begin
                    n_phase = PH_DATA_CR;
                end
            end
            PH_DATA_CR: begin
                n_phase = (i_byte == CH_CR) ? PH_DATA_LF : PH_ERROR;
            end
            PH_DATA_LF: begin
                n_phase = (i_byte == CH_LF) ? PH_SIZE : PH_ERROR;
            end
            PH_TRAILER: begin
                if (i_byte == CH_LF && e_tcr) begin
                    n_phase = PH_DONE;
                end
            end
            default: begin
                n_phase = e_phase;
            end
        endcase
    end

    // Datapath updates and the result for this byte.
    always_comb begin
        n_accum = e_accum;
        n_flags = e_flags;
        n_left  = e_left;
        n_total = e_total;
        n_tcr   = e_tcr;
        kind    = KIND_FRAMING;
        obyte   = '0;
        case (e_phase)
            PH_SIZE, PH_EXT: begin
                if (e_flags.cr) begin
                    if (i_byte == CH_LF && !size_bad) begin
                        n_left  = e_accum;
                        n_accum = '0;
                        n_flags = '0;
                    end
                end else if (i_byte == CH_CR) begin
                    n_flags.cr = 1'b1;
                end else if (e_phase == PH_SIZE && i_byte == CH_SPACE) begin
                    n_flags.space = 1'b1;
                end else if (e_phase == PH_SIZE && i_byte != CH_SEMI && hex_ok) begin
                    n_flags.digit = 1'b1;
                    if (top_nibble_used) begin
                        n_flags.over = 1'b1;
                    end else begin
                        n_accum = {e_accum[SIZE_WIDTH-DIGIT_W-1:0], hex_val};
                    end
                end
            end
            PH_DATA: begin
                kind   = KIND_PAYLOAD;
                obyte  = i_byte;
                n_left = left_dec;
                if (e_total != '1) begin
                    n_total = e_total + TOTAL_WIDTH'(1);
                end
            end
            PH_DATA_CR, PH_DATA_LF: begin
                kind = KIND_FRAMING;
            end
            PH_TRAILER: begin
                if (i_byte == CH_CR) begin
                    n_tcr = 1'b1;
                end else if (i_byte == CH_LF) begin
                    n_tcr = 1'b0;
                end else begin
                    n_tcr = 1'b0;
                    kind  = KIND_TRAILER;
                    obyte = (i_byte >= CH_UP_A && i_byte <= CH_UP_Z) ?
                            (i_byte | CASE_BIT) : i_byte;
                end
            end
            default: begin
                kind = KIND_IGNORED;
            end
        endcase
    end

    // Body status follows the phase after this byte.
    always_comb begin
        case (n_phase)
            PH_DONE:  status = ST_DONE;
            PH_ERROR: status = ST_INVALID;
            default:  status = ST_MORE;
        endcase
    end

    assign o_result.kind     = kind;
    assign o_result.out_byte = obyte;
    assign o_result.status   = status;
    assign o_result.total    = OUT_TOTAL_W'(n_total);

    // Control state, updated on each input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIZE;
            r_flags <= '0;
            r_tcr   <= 1'b0;
            r_accum <= '0;
            r_left  <= '0;
            r_total <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_flags <= n_flags;
            r_tcr   <= n_tcr;
            r_accum <= n_accum;
            r_left  <= n_left;
            r_total <= n_total;
        end
    end

endmodule

`default_nettype wire

@@ sv/chbd_checker.sv @@
`default_nettype none

module chbd_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_cfg_wr_en,
    input wire logic [chbd_pkg::MAX_SIZE_W-1:0] i_cfg_wr_data,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic [7:0]                      s_axis_tdata,
    input wire logic [0:0]                      s_axis_tuser,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [63:0]                     m_axis_tdata,
    input wire logic [1:0]                      m_axis_tuser
);
    import chbd_pkg::*;

    logic [7:0] obyte;
    logic [1:0] status;
    logic       unused_in;

    assign obyte     = m_axis_tdata[7:0];
    assign status    = m_axis_tdata[9:8];
    assign unused_in = i_cfg_wr_en ^ (|i_cfg_wr_data) ^ s_axis_tvalid ^ s_axis_tready ^
                       (|s_axis_tdata) ^ s_axis_tuser[0];

    // A stalled result holds its contents.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    // Nothing is offered right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // A byte is ignored only once the body has completed or failed.
    a_ignored_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_IGNORED |-> status != ST_MORE)
        else $error("ignored byte while body still open");

    // A payload byte always leaves the body open.
    a_payload_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_PAYLOAD |-> status == ST_MORE)
        else $error("payload byte closed the body");

    // Trailer characters are folded and never line breaks.
    a_trailer_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_TRAILER |->
        obyte != CH_CR && obyte != CH_LF && !(obyte >= CH_UP_A && obyte <= CH_UP_Z)
        && unused_in == unused_in)
        else $error("bad trailer character");

endmodule

bind http_chunked_body_decoder_unit chbd_checker u_chbd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_wr_en   (i_cfg_wr_en),
    .i_cfg_wr_data (i_cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ tb/sv/http_chunked_body_decoder_unit_tb.sv @@
`default_nettype none

module http_chunked_body_decoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import chbd_pkg::*;

    // One body byte waiting to be sent, with an optional hand-written result.
    typedef struct packed {
        logic [7:0] data;
        logic       restart;
        logic       typed;
        t_result    want;
    } t_body_byte;

    // Ready patterns of the result sink.
    typedef enum int {
        RX_FREE,
        RX_RANDOM,
        RX_PATTERN,
        RX_HEAVY
    } t_rx_mode;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [MAX_SIZE_W-1:0] i_cfg_wr_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = 8'h00;  // [7:0] in_byte
    logic [0:0]            s_axis_tuser  = 1'b0;   // [0] restart
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [7:0] out_byte, [9:8] body_status, [57:10] payload_total, [63:58] zero
    logic [63:0]           m_axis_tdata;
    logic [1:0]            m_axis_tuser;           // [1:0] byte_kind

    // Bytes not yet transferred, and decoded results not yet seen.
    t_body_byte pending_bytes[$];
    t_result    decoded_q[$];
    t_body_byte dir_table[$];

    // Decoder state as predicted by the testbench.
    logic [31:0]           max_size_model = MAX_SIZE_RESET;
    t_phase                dec_phase;
    logic [SIZE_WIDTH-1:0] dec_accum;
    t_size_flags           dec_flags;
    logic [SIZE_WIDTH-1:0] dec_left;
    logic [TOTAL_WIDTH-1:0] dec_total;
    logic                  dec_trailer_cr;

    int  mismatch_count = 0;
    int  results_seen   = 0;
    int  queued_count   = 0;
    logic start_flag    = 1'b0;

    // Sender burst shaping.
    int burst_left = 1;
    int gap_left   = 0;

    // Receiver stall shaping.
    t_rx_mode   rx_mode       = RX_FREE;
    int         rx_mode_left  = 0;
    logic [7:0] rx_pattern    = 8'hFF;
    int         hold_left     = 0;
    logic       hold_done     = 1'b0;

    http_chunked_body_decoder_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Clear the predicted parser state; the size limit is kept.
    task automatic clear_decoder();
        dec_phase      = PH_SIZE;
        dec_accum      = '0;
        dec_flags      = '0;
        dec_left       = '0;
        dec_total      = '0;
        dec_trailer_cr = 1'b0;
    endtask

    // Predict the result for one transferred body byte and advance the state.
    task automatic decode_byte(input logic [7:0] c, input logic restart, output t_result res);
        int nib;
        res.kind     = KIND_FRAMING;
        res.out_byte = 8'h00;
        if (restart) begin
            clear_decoder();
        end
        case (dec_phase)
            PH_SIZE, PH_EXT: begin
                if (dec_flags.cr) begin
                    // The size line ends here; the line is judged as a whole.
                    if (c != CH_LF) begin
                        dec_phase = PH_ERROR;
                    end else if (!dec_flags.digit || dec_flags.space || dec_flags.over ||
                                 dec_accum > max_size_model) begin
                        dec_phase = PH_ERROR;
                    end else begin
                        dec_left  = dec_accum;
                        dec_phase = (dec_accum == '0) ? PH_TRAILER : PH_DATA;
                        dec_accum = '0;
                        dec_flags = '0;
                    end
                end else if (c == CH_CR) begin
                    dec_flags.cr = 1'b1;
                end else if (dec_phase != PH_EXT) begin
                    if (c == CH_SEMI) begin
                        dec_phase = PH_EXT;
                    end else if (c == CH_SPACE) begin
                        dec_flags.space = 1'b1;
                    end else begin
                        if (c >= 8'h30 && c <= 8'h39) begin
                            nib = c - 8'h30;
                        end else if (c >= 8'h61 && c <= 8'h66) begin
                            nib = c - 8'h61 + 10;
                        end else if (c >= 8'h41 && c <= 8'h46) begin
                            nib = c - 8'h41 + 10;
                        end else begin
                            nib = -1;
                        end
                        if (nib < 0) begin
                            dec_phase = PH_ERROR;
                        end else begin
                            dec_flags.digit = 1'b1;
                            if (dec_accum > (32'hFFFF_FFFF >> 4)) begin
                                dec_flags.over = 1'b1;
                            end else begin
                                dec_accum = {dec_accum[SIZE_WIDTH-5:0], nib[3:0]};
                            end
                        end
                    end
                end
            end
            PH_DATA: begin
                res.kind     = KIND_PAYLOAD;
                res.out_byte = c;
                if (dec_total != '1) begin
                    dec_total = dec_total + 1'b1;
                end
                dec_left = dec_left - 1'b1;
                if (dec_left == '0) begin
                    dec_phase = PH_DATA_CR;
                end
            end
            PH_DATA_CR: begin
                dec_phase = (c == CH_CR) ? PH_DATA_LF : PH_ERROR;
            end
            PH_DATA_LF: begin
                dec_phase = (c == CH_LF) ? PH_SIZE : PH_ERROR;
            end
            PH_TRAILER: begin
                // A CR followed directly by an LF ends the trailer.
                if (c == CH_CR) begin
                    dec_trailer_cr = 1'b1;
                end else if (c == CH_LF) begin
                    if (dec_trailer_cr) begin
                        dec_phase = PH_DONE;
                    end
                    dec_trailer_cr = 1'b0;
                end else begin
                    dec_trailer_cr = 1'b0;
                    res.kind       = KIND_TRAILER;
                    res.out_byte   = (c >= CH_UP_A && c <= CH_UP_Z) ? (c | CASE_BIT) : c;
                end
            end
            default: begin
                res.kind = KIND_IGNORED;
            end
        endcase
        res.status = (dec_phase == PH_DONE)  ? ST_DONE :
                     (dec_phase == PH_ERROR) ? ST_INVALID : ST_MORE;
        res.total  = dec_total;
    endtask

    // Print one line for a mismatch and count it.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < 40) begin
            $display("mismatch at result %0d: %s got %0h want %0h",
                     results_seen, what, got, want);
        end
        mismatch_count++;
    endtask

    function automatic t_body_byte plain_row(input logic [7:0] b, input logic restart);
        t_body_byte row;
        row         = '0;
        row.data    = b;
        row.restart = restart;
        return row;
    endfunction

    function automatic t_body_byte checked_row(input logic [7:0] b, input logic restart,
                                               input t_kind kind, input logic [7:0] ob,
                                               input t_status st, input logic [47:0] total);
        t_body_byte row;
        row               = plain_row(b, restart);
        row.typed         = 1'b1;
        row.want.kind     = kind;
        row.want.out_byte = ob;
        row.want.status   = st;
        row.want.total    = total;
        return row;
    endfunction

    // Append one row to the directed stimulus table.
    task automatic add_row(input t_body_byte row);
        dir_table = {dir_table, row};
    endtask

    // Queue one byte for the sender; the first byte of a body carries restart.
    task automatic push_byte(input logic [7:0] b);
        pending_bytes = {pending_bytes, plain_row(b, start_flag)};
        start_flag = 1'b0;
        queued_count++;
    endtask

    task automatic push_hex(input logic [3:0] nib);
        if (nib < 4'd10) begin
            push_byte(8'h30 + 8'(nib));
        end else if ($urandom_range(0, 1) == 0) begin
            push_byte(8'h41 + 8'(nib) - 8'd10);
        end else begin
            push_byte(8'h61 + 8'(nib) - 8'd10);
        end
    endtask

    // A chunk size line, mostly well formed, sometimes with a flaw.
    task automatic push_size_line(input logic [31:0] value, input bit overflow);
        int         ndig;
        logic [7:0] b;
        if (overflow) begin
            push_hex(4'($urandom_range(1, 15)));
            repeat ($urandom_range(8, 9)) push_hex(4'($urandom_range(0, 15)));
        end else begin
            ndig = 1;
            for (int i = 1; i < 8; i++) begin
                if (value[4*i +: 4] != 4'd0) begin
                    ndig = i + 1;
                end
            end
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 2)) push_hex(4'd0);
            end
            for (int i = ndig - 1; i >= 0; i--) begin
                push_hex(value[4*i +: 4]);
            end
        end
        case ($urandom_range(0, 29))
            0: push_byte(CH_SPACE);
            1: push_byte(8'($urandom_range(0, 255)));
            default: ;
        endcase
        // Optional extension, skipped by the block up to the CR.
        if ($urandom_range(0, 4) == 0) begin
            push_byte(CH_SEMI);
            repeat ($urandom_range(0, 4)) begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_CR) begin
                    b = 8'h78;
                end
                push_byte(b);
            end
        end
        push_byte(CH_CR);
        if ($urandom_range(0, 29) == 0) begin
            push_byte(8'($urandom_range(0, 255)));
        end else begin
            push_byte(CH_LF);
        end
    endtask

    // One chunked body: a few chunks, the last chunk, a trailer, then stray bytes.
    task automatic queue_body();
        int          k;
        int          len;
        logic [31:0] sz;
        bit          ovf;
        start_flag = ($urandom_range(0, 19) != 0);
        repeat ($urandom_range(0, 3)) begin
            k   = $urandom_range(0, 99);
            ovf = 1'b0;
            if (k < 75) begin
                sz  = $urandom_range(1, 8);
                len = sz;
            end else if (k < 80) begin
                sz  = $urandom_range(9, 40);
                len = sz;
            end else if (k < 88) begin
                sz  = max_size_model + 32'($urandom_range(0, 1));
                len = (sz <= 64) ? int'(sz) : $urandom_range(0, 3);
            end else if (k < 93) begin
                sz  = '0;
                ovf = 1'b1;
                len = $urandom_range(0, 3);
            end else begin
                sz  = $urandom;
                len = $urandom_range(0, 3);
            end
            push_size_line(sz, ovf);
            repeat (len) push_byte(8'($urandom_range(0, 255)));
            // Chunk terminator, occasionally broken.
            k = $urandom_range(0, 39);
            if (k == 0) begin
                push_byte(8'($urandom_range(0, 255)));
            end else if (k == 1) begin
                push_byte(CH_CR);
                push_byte(8'($urandom_range(0, 255)));
            end else begin
                push_byte(CH_CR);
                push_byte(CH_LF);
            end
        end
        push_size_line(32'd0, 1'b0);
        // Trailer with lone line breaks and mixed case text.
        repeat ($urandom_range(0, 6)) begin
            k = $urandom_range(0, 9);
            if (k == 0) begin
                push_byte(CH_LF);
            end else if (k == 1) begin
                push_byte(CH_CR);
            end else if (k < 6) begin
                push_byte(CH_UP_A + 8'($urandom_range(0, 25)));
            end else if (k < 8) begin
                push_byte(8'h61 + 8'($urandom_range(0, 25)));
            end else begin
                push_byte(8'($urandom_range(0, 255)));
            end
        end
        push_byte(CH_CR);
        push_byte(CH_LF);
        repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic queue_noise(input int n);
        repeat (n) begin
            start_flag = ($urandom_range(0, 15) == 0);
            push_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic queue_random(input int target);
        int first;
        first = queued_count;
        while (queued_count - first < target) begin
            if ($urandom_range(0, 99) < 85) begin
                queue_body();
            end else begin
                queue_noise($urandom_range(1, 10));
            end
        end
    endtask

    // Wait until every byte is transferred and every result seen, then settle.
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_bytes.size() != 0 || decoded_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_max_size(input logic [31:0] v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        max_size_model = v;
    endtask

    // Sender: bursts with gaps; the prediction is made at each transfer.
    always @(posedge i_clk) begin
        t_result res;
        logic    hold;
        logic    next_valid;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            clear_decoder();
            burst_left = 1;
            gap_left   = 0;
        end else begin
            hold = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                decode_byte(pending_bytes[0].data, pending_bytes[0].restart, res);
                if (pending_bytes[0].typed) begin
                    decoded_q = {decoded_q, pending_bytes[0].want};
                end else begin
                    decoded_q = {decoded_q, res};
                end
                pending_bytes.pop_front();
                hold = 1'b0;
            end
            if (hold) begin
                next_valid = 1'b1;
            end else if (gap_left != 0) begin
                gap_left   = gap_left - 1;
                next_valid = 1'b0;
            end else if (pending_bytes.size() != 0) begin
                next_valid = 1'b1;
                s_axis_tdata <= pending_bytes[0].data;
                s_axis_tuser <= pending_bytes[0].restart;
                burst_left = burst_left - 1;
                if (burst_left <= 0) begin
                    if ($urandom_range(0, 9) == 0) begin
                        burst_left = $urandom_range(100, 300);
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = $urandom_range(0, 6);
                    end
                end
            end else begin
                next_valid = 1'b0;
            end
            s_axis_tvalid <= next_valid;
        end
    end

    // Receiver: checks each result transfer and stalls on its own pattern.
    always @(posedge i_clk) begin
        t_result want;
        logic    ready_next;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch("result with no byte pending", m_axis_tdata, 64'd0);
                end else begin
                    want = decoded_q.pop_front();
                    if (m_axis_tuser !== want.kind)
                        report_mismatch("byte_kind", 64'(m_axis_tuser), 64'(want.kind));
                    if (m_axis_tdata[7:0] !== want.out_byte)
                        report_mismatch("out_byte", 64'(m_axis_tdata[7:0]), 64'(want.out_byte));
                    if (m_axis_tdata[9:8] !== want.status)
                        report_mismatch("body_status", 64'(m_axis_tdata[9:8]),
                                        64'(want.status));
                    if (m_axis_tdata[57:10] !== want.total)
                        report_mismatch("payload_total", 64'(m_axis_tdata[57:10]),
                                        64'(want.total));
                    if (m_axis_tdata[63:58] !== 6'd0)
                        report_mismatch("tdata padding", 64'(m_axis_tdata[63:58]), 64'd0);
                end
                results_seen++;
            end
            // One long hold-off lets the block fill up and stall its input.
            if (hold_left != 0) begin
                hold_left  = hold_left - 1;
                ready_next = 1'b0;
            end else if (!hold_done && results_seen >= 300) begin
                hold_done  = 1'b1;
                hold_left  = 400;
                ready_next = 1'b0;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode      = t_rx_mode'($urandom_range(0, 3));
                    rx_mode_left = $urandom_range(20, 80);
                    rx_pattern   = 8'($urandom_range(0, 255));
                end
                rx_mode_left = rx_mode_left - 1;
                case (rx_mode)
                    RX_FREE: ready_next = 1'b1;
                    RX_RANDOM: ready_next = ($urandom_range(0, 2) != 0);
                    RX_PATTERN: begin
                        ready_next = rx_pattern[0];
                        rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
                    end
                    default: ready_next = ($urandom_range(0, 4) == 0);
                endcase
            end
            m_axis_tready <= ready_next;
        end
    end

    // Stimulus sequence and end of run.
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Payload byte at the top of the range, then no CRLF after the data.
        add_row(plain_row(8'h31, 1'b1));
        add_row(plain_row(CH_CR, 1'b0));
        add_row(plain_row(CH_LF, 1'b0));
        add_row(checked_row(8'hFF, 1'b0, KIND_PAYLOAD, 8'hFF, ST_MORE, 48'd1));
        add_row(checked_row(8'h62, 1'b0, KIND_FRAMING, 8'h00, ST_INVALID, 48'd1));
        // Last chunk with an extension, trailer folding, lone LF, then finish.
        add_row(plain_row(8'h30, 1'b1));
        add_row(plain_row(CH_SEMI, 1'b0));
        add_row(plain_row(8'h51, 1'b0));
        add_row(plain_row(CH_CR, 1'b0));
        add_row(plain_row(CH_LF, 1'b0));
        add_row(checked_row(8'h58, 1'b0, KIND_TRAILER, 8'h78, ST_MORE, 48'd0));
        add_row(plain_row(CH_LF, 1'b0));
        add_row(plain_row(CH_CR, 1'b0));
        add_row(checked_row(CH_LF, 1'b0, KIND_FRAMING, 8'h00, ST_DONE, 48'd0));
        add_row(checked_row(8'h5A, 1'b0, KIND_IGNORED, 8'h00, ST_DONE, 48'd0));
        // A space on the size line.
        add_row(plain_row(CH_SPACE, 1'b1));
        add_row(plain_row(CH_CR, 1'b0));
        add_row(checked_row(CH_LF, 1'b0, KIND_FRAMING, 8'h00, ST_INVALID, 48'd0));
        // A character that cannot stand on a size line.
        add_row(checked_row(8'h67, 1'b1, KIND_FRAMING, 8'h00, ST_INVALID, 48'd0));
        // CR not followed by LF.
        add_row(plain_row(CH_CR, 1'b1));
        add_row(checked_row(8'h61, 1'b0, KIND_FRAMING, 8'h00, ST_INVALID, 48'd0));
        // Empty size line.
        add_row(plain_row(CH_CR, 1'b1));
        add_row(checked_row(CH_LF, 1'b0, KIND_FRAMING, 8'h00, ST_INVALID, 48'd0));
        foreach (dir_table[i]) begin
            pending_bytes = {pending_bytes, dir_table[i]};
            queued_count++;
        end

        queue_random(200);
        wait_drained();

        // Limit extremes, then a small limit and the reset value again.
        write_max_size(32'd0);
        queue_random(80);
        wait_drained();

        write_max_size(32'hFFFF_FFFF);
        queue_random(150);
        wait_drained();

        write_max_size(32'($urandom_range(1, 40)));
        queue_random(200);
        wait_drained();

        write_max_size(MAX_SIZE_RESET);
        queue_random(150);
        wait_drained();

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #3_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
